/* design/rlmtf_pkg.sv */
package rlmtf_pkg;

  // Default number of list entries.
  localparam int DEFAULT_LIST_DEPTH = 8;

  // Field widths of the transaction payloads.
  localparam int ID_W    = 8;
  localparam int OPC_W   = 3;
  localparam int POS_W   = 8;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;
  localparam int CFG_A_W = 2;

  // Reset values of the configuration registers.
  localparam logic [ID_W-1:0] ALLOWED_A_RST = 8'd1;
  localparam logic [ID_W-1:0] ALLOWED_B_RST = 8'd2;
  localparam logic [ID_W-1:0] ALLOWED_C_RST = 8'd3;
  localparam logic [ID_W-1:0] NULL_ID_RST   = 8'd0;

  // Operation codes.
  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_A_W-1:0] {
    REG_ALLOWED_A = 2'd0,
    REG_ALLOWED_B = 2'd1,
    REG_ALLOWED_C = 2'd2,
    REG_NULL_ID   = 2'd3
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic execute;
  } cmd_t;

endpackage

/* design/rlmtf_ctrl.sv */
module rlmtf_ctrl
  import rlmtf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_stall    = 1'b1;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MATCH: begin
        cmd.compare = 1'b1;
      end
      ST_EXEC: begin
        cmd.execute = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Output transaction flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* design/rlmtf_datapath.sv */
module rlmtf_datapath
  import rlmtf_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [ID_W-1:0]    cfg_data,
  input  logic [OPC_W-1:0]   opcode,
  input  logic [ID_W-1:0]    item_id,
  input  logic [POS_W-1:0]   position,
  output logic [ID_W-1:0]    id_out,
  output logic               found,
  output logic [IDX_W-1:0]   index_out,
  output logic [CNT_W-1:0]   count_out
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (POS_W > CW) ? POS_W : CW;

  // Configuration registers.
  logic [ID_W-1:0] allowed_a;
  logic [ID_W-1:0] allowed_b;
  logic [ID_W-1:0] allowed_c;
  logic [ID_W-1:0] null_id;

  // Captured transaction and list state.
  logic [OPC_W-1:0]      op_r;
  logic [ID_W-1:0]       item_r;
  logic [POS_W-1:0]      pos_r;
  logic [LIST_DEPTH-1:0] match_vec;
  logic [ID_W-1:0]       entries [LIST_DEPTH];
  logic [CW-1:0]         count;

  // Execute-cycle signals.
  logic [ID_W-1:0] entries_next [LIST_DEPTH];
  logic [CW-1:0]   count_next;
  logic            hit_any;
  logic [IW-1:0]   hit_idx;
  logic            pos_ok;
  logic            is_allowed;
  logic            push;
  logic [IW-1:0]   push_top;
  logic            del;
  logic [ID_W-1:0] id_c;
  logic            found_c;
  logic [IW-1:0]   idx_c;
  logic [IW+IDX_W-1:0] idx_ext;
  logic [CW+CNT_W-1:0] cnt_ext;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_a <= ALLOWED_A_RST;
      allowed_b <= ALLOWED_B_RST;
      allowed_c <= ALLOWED_C_RST;
      null_id   <= NULL_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALLOWED_A: allowed_a <= cfg_data;
        REG_ALLOWED_B: allowed_b <= cfg_data;
        REG_ALLOWED_C: allowed_c <= cfg_data;
        REG_NULL_ID:   null_id   <= cfg_data;
        default:       null_id   <= null_id;
      endcase
    end
  end

  // Capture the incoming transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode;
      item_r <= item_id;
      pos_r  <= position;
    end
  end

  // Compare every occupied entry with the item id in parallel.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        match_vec[k] <= (entries[k] == item_r) && (k < int'(count));
      end
    end
  end

  // First matching position.
  always_comb begin
    hit_any = |match_vec;
    hit_idx = '0;
    for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        hit_idx = IW'(k);
      end
    end
  end

  assign pos_ok     = (PW'(pos_r) < PW'(count));
  assign is_allowed = (item_r != null_id) &&
                      ((item_r == allowed_a) || (item_r == allowed_b) ||
                       (item_r == allowed_c));

  // Operation decode.
  always_comb begin
    push       = 1'b0;
    push_top   = '0;
    del        = 1'b0;
    count_next = count;
    id_c       = null_id;
    found_c    = 1'b0;
    idx_c      = '0;
    unique case (op_t'(op_r))
      OP_ADD: begin
        if (hit_any) begin
          push     = 1'b1;
          push_top = hit_idx;
          found_c  = 1'b1;
        end else if (is_allowed) begin
          push    = 1'b1;
          found_c = 1'b1;
          if (count == CW'(LIST_DEPTH)) begin
            push_top = IW'(LIST_DEPTH - 1);
          end else begin
            push_top   = count[IW-1:0];
            count_next = count + CW'(1);
          end
        end
      end
      OP_DELETE: begin
        if (pos_ok) begin
          del        = 1'b1;
          found_c    = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_GET: begin
        if (pos_ok) begin
          id_c    = entries[pos_r[IW-1:0]];
          found_c = 1'b1;
        end
      end
      OP_FIND: begin
        found_c = hit_any;
        idx_c   = hit_idx;
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        found_c = 1'b0;
      end
    endcase
  end

  // Shift network: push toward the back or close up toward the front.
  always_comb begin
    for (int k = 0; k < LIST_DEPTH; k++) begin
      entries_next[k] = entries[k];
    end
    if (push) begin
      entries_next[0] = item_r;
      for (int k = 1; k < LIST_DEPTH; k++) begin
        if (k <= int'(push_top)) begin
          entries_next[k] = entries[k-1];
        end
      end
    end
    if (del) begin
      for (int k = 0; k < LIST_DEPTH - 1; k++) begin
        if (k >= int'(pos_r)) begin
          entries_next[k] = entries[k+1];
        end
      end
    end
  end

  // List storage, updated once per transaction.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        entries[k] <= entries_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // Result register.
  assign idx_ext = {{IDX_W{1'b0}}, idx_c};
  assign cnt_ext = {{CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      id_out    <= id_c;
      found     <= found_c;
      index_out <= idx_ext[IDX_W-1:0];
      count_out <= cnt_ext[CNT_W-1:0];
    end
  end

endmodule

/* design/recent_list_move_to_front_core.sv */
// Most-recently-used list of 8-bit ids with move-to-front on add. Each input
// transaction (add, delete, get, find or clear) returns exactly one result
// transaction. An item is captured first; then the parallel compare of every
// list entry against the item id is registered; then the shift network runs
// and loads the result register. The block takes no new item before the
// last one has reached the result register; a result waiting under out_stall
// holds the next item in its execute cycle.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// may only change while no transaction is in flight.
module recent_list_move_to_front_core
  import rlmtf_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [ID_W-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OPC_W-1:0]   opcode,
  input  logic [ID_W-1:0]    item_id,
  input  logic [POS_W-1:0]   position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    id_out,
  output logic               found,
  output logic [IDX_W-1:0]   index_out,
  output logic [CNT_W-1:0]   count_out
);

  cmd_t cmd;

  // Sequencer.
  rlmtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // List storage, compare and shift network.
  rlmtf_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .item_id   (item_id),
    .position  (position),
    .id_out    (id_out),
    .found     (found),
    .index_out (index_out),
    .count_out (count_out)
  );

endmodule

/* design/rlmtf_checker.sv */
module rlmtf_checker
  import rlmtf_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ID_W-1:0]    id_out,
  input logic               found,
  input logic [IDX_W-1:0]   index_out,
  input logic [CNT_W-1:0]   count_out
);

  // One transaction at a time: input is stalled right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in flight");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(id_out) && $stable(count_out))
    else $error("stalled result changed or dropped");

  // The reported count never exceeds the list depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(count_out) <= LIST_DEPTH))
    else $error("count exceeds list depth");

  // A miss always reports position zero.
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> index_out == '0)
    else $error("nonzero index on a miss");

endmodule

bind recent_list_move_to_front_core rlmtf_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_rlmtf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .id_out    (id_out),
  .found     (found),
  .index_out (index_out),
  .count_out (count_out)
);
